[hdl/rqps_pkg.sv]
// Shared types and constants for the ready queue with priority select.
package rqps_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int KIND_W = 2;
   localparam int ID_W   = 8;
   localparam int PRI_W  = 8;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   // Operation codes; the fourth code is a no-op
   typedef enum logic [KIND_W-1:0] {
      KIND_ENQ = 2'd0,
      KIND_DEQ = 2'd1,
      KIND_REM = 2'd2
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE     = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_PACK,
      SEQ_FINISH
   } seq_state_type;

   // One stored entry
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] pri;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Request as seen by the sequencer
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   task_id;
      logic [PRI_W-1:0]  task_priority;
   } req_type;

   // Result handed from the sequencer to the output register
   typedef struct packed {
      logic [ID_W-1:0]   out_id;
      logic [PRI_W-1:0]  out_priority;
      logic [STAT_W-1:0] status;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

endpackage

[hdl/rqps_req_if.sv]
// Request channel interface: valid/ready plus operation fields.
interface rqps_req_if import rqps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ID_W-1:0]   task_id;
   logic [PRI_W-1:0]  task_priority;

   modport source (output valid, output kind, output task_id, output task_priority,
                   input ready);
   modport sink   (input valid, input kind, input task_id, input task_priority,
                   output ready);
endinterface

[hdl/rqps_rsp_if.sv]
// Response channel interface: valid/ready plus result fields.
interface rqps_rsp_if import rqps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   out_id;
   logic [PRI_W-1:0]  out_priority;
   logic [STAT_W-1:0] status;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, output out_id, output out_priority, output status,
                   output occupancy, input ready);
   modport sink   (input valid, input out_id, input out_priority, input status,
                   input occupancy, output ready);
endinterface

[hdl/rqps_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module rqps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/rqps_seq.sv]
// Queue sequencer: owns the entry RAM, runs the min-priority scan and the compaction pass.
module rqps_seq import rqps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fifo_mode,
   input  logic    start,
   input  req_type req,
   output logic    idle,
   output logic    res_valid,
   input  logic    res_take,
   output rsp_type res
);

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0] dat_idx_ff, dat_idx_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [PRI_W-1:0]  best_pri_ff, best_pri_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;
   logic [ID_W-1:0]   got_id_ff, got_id_in;
   logic [PRI_W-1:0]  got_pri_ff, got_pri_in;
   status_type        status_ff, status_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   entry_type         ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   entry_type         ram_q;
   logic              pass_end;
   logic              drop;

   rqps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH),
      .AW    (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SEQ_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      rd_idx_ff   <= rd_idx_in;
      dat_idx_ff  <= dat_idx_in;
      best_idx_ff <= best_idx_in;
      best_pri_ff <= best_pri_in;
      keep_ff     <= keep_in;
      got_id_ff   <= got_id_in;
      got_pri_ff  <= got_pri_in;
      status_ff   <= status_in;
   end

   // Pass is over once the read index reaches the count and the last read data was consumed
   assign pass_end = (rd_idx_ff == count_ff) && !rd_vld_ff;

   // Next state, RAM control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      kind_in     = kind_ff;
      id_in       = id_ff;
      rd_idx_in   = rd_idx_ff;
      rd_vld_in   = 1'b0;
      dat_idx_in  = dat_idx_ff;
      best_idx_in = best_idx_ff;
      best_pri_in = best_pri_ff;
      keep_in     = keep_ff;
      got_id_in   = got_id_ff;
      got_pri_in  = got_pri_ff;
      status_in   = status_ff;
      ram_we      = 1'b0;
      ram_waddr   = keep_ff[ADDR_W-1:0];
      ram_wdata   = ram_q;
      ram_re      = 1'b0;
      ram_raddr   = rd_idx_ff[ADDR_W-1:0];
      drop        = 1'b0;
      idle        = 1'b0;
      res_valid   = 1'b0;

      case (state_ff)
         SEQ_IDLE: begin
            idle = 1'b1;
            if (start) begin
               kind_in     = req.kind;
               id_in       = req.task_id;
               got_id_in   = '0;
               got_pri_in  = '0;
               status_in   = ST_DONE;
               rd_idx_in   = '0;
               keep_in     = '0;
               best_idx_in = '0;
               case (req.kind)
                  KIND_ENQ: begin
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_we        = 1'b1;
                        ram_waddr     = count_ff[ADDR_W-1:0];
                        ram_wdata.id  = req.task_id;
                        ram_wdata.pri = req.task_priority;
                        count_in      = count_ff + 1'b1;
                     end
                     state_in = SEQ_FINISH;
                  end
                  KIND_DEQ: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = SEQ_FINISH;
                     end else if (fifo_mode) begin
                        state_in = SEQ_PACK;
                     end else begin
                        state_in = SEQ_SCAN;
                     end
                  end
                  KIND_REM: begin
                     state_in = SEQ_PACK;
                  end
                  default: begin
                     state_in = SEQ_FINISH;
                  end
               endcase
            end
         end

         // Walk all entries, keep the first one with the smallest priority
         SEQ_SCAN: begin
            if (rd_idx_ff != count_ff) begin
               ram_re     = 1'b1;
               rd_vld_in  = 1'b1;
               dat_idx_in = rd_idx_ff[ADDR_W-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if ((dat_idx_ff == '0) || (ram_q.pri < best_pri_ff)) begin
                  best_idx_in = dat_idx_ff;
                  best_pri_in = ram_q.pri;
               end
            end
            if (pass_end) begin
               rd_idx_in = CNT_W'(best_idx_ff);
               keep_in   = CNT_W'(best_idx_ff);
               state_in  = SEQ_PACK;
            end
         end

         // Read entry i, write it back at the keep slot unless it is dropped
         SEQ_PACK: begin
            if (rd_idx_ff != count_ff) begin
               ram_re     = 1'b1;
               rd_vld_in  = 1'b1;
               dat_idx_in = rd_idx_ff[ADDR_W-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (kind_ff == KIND_DEQ) begin
                  drop = (dat_idx_ff == best_idx_ff);
               end else begin
                  drop = (ram_q.id == id_ff);
               end
               if (drop) begin
                  if (kind_ff == KIND_DEQ) begin
                     got_id_in  = ram_q.id;
                     got_pri_in = ram_q.pri;
                  end
               end else begin
                  ram_we  = 1'b1;
                  keep_in = keep_ff + 1'b1;
               end
            end
            if (pass_end) begin
               count_in = keep_ff;
               if ((kind_ff == KIND_REM) && (keep_ff == count_ff)) begin
                  status_in = ST_NOTFOUND;
               end
               state_in = SEQ_FINISH;
            end
         end

         SEQ_FINISH: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Result fields
   assign res.out_id       = got_id_ff;
   assign res.out_priority = got_pri_ff;
   assign res.status       = status_ff;
   assign res.occupancy    = OCC_W'(count_ff);

endmodule

[hdl/ready_queue_priority_select.sv]
// Top level of the ready queue with priority select.
//
// Channels: req_chan takes one request (enqueue, dequeue or remove by handle)
// on a valid/ready handshake; rsp_chan returns exactly one response per
// request, in order, carrying the dequeued handle and priority, a status
// code and the occupancy after the operation. csr_wr_en/csr_wr_data write
// the fifo_mode bit (1: oldest first, 0: smallest priority first).
//
// Entries live in a 16-deep synchronous RAM, so most operations are a walk:
//   enqueue, no-op, full or empty cases : answered straight from idle
//   remove                              : one compaction pass
//   dequeue, oldest first               : one compaction pass
//   dequeue, smallest priority          : priority scan, then compaction pass
// All walks share the single RAM read port (one entry read per cycle for the
// priority scan and again for the compaction pass). One request is in
// work at a time; req ready is high only while the sequencer is idle.
// The response sits in an output register, so a new request is taken
// while an earlier response waits; a stalled receiver holds the next
// finished result in the sequencer. Reset empties the queue, clears
// fifo_mode and drops any pending response.
module ready_queue_priority_select import rqps_pkg::*; (
   input  logic clock,
   input  logic reset,
   rqps_req_if.sink   req_chan,
   rqps_rsp_if.source rsp_chan,
   input  logic csr_wr_en,
   input  logic csr_wr_data
);

   logic    fifo_mode_ff, fifo_mode_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    seq_idle;
   logic    seq_res_valid;
   logic    res_take;
   logic    start;
   req_type req;
   rsp_type seq_res;

   // Request decode
   assign req.kind          = req_chan.kind;
   assign req.task_id       = req_chan.task_id;
   assign req.task_priority = req_chan.task_priority;
   assign req_chan.ready    = seq_idle;
   assign start             = req_chan.valid && seq_idle;

   rqps_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .fifo_mode (fifo_mode_ff),
      .start     (start),
      .req       (req),
      .idle      (seq_idle),
      .res_valid (seq_res_valid),
      .res_take  (res_take),
      .res       (seq_res)
   );

   // Mode register
   assign fifo_mode_in = csr_wr_en ? csr_wr_data : fifo_mode_ff;

   // Output register: loads when empty or being drained
   assign res_take = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = seq_res_valid;
         if (seq_res_valid) begin
            rsp_data_in = seq_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fifo_mode_ff <= fifo_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_id       = rsp_data_ff.out_id;
   assign rsp_chan.out_priority = rsp_data_ff.out_priority;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.occupancy    = rsp_data_ff.occupancy;

endmodule

[hdl/rqps_checker.sv]
// Port-level assertions for the ready queue, bound to the top level.
module rqps_checker import rqps_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ID_W-1:0]   out_id,
   input logic [PRI_W-1:0]  out_priority,
   input logic [STAT_W-1:0] status,
   input logic [OCC_W-1:0]  occupancy
);

   // No response survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_id) && $stable(out_priority)
         && $stable(status) && $stable(occupancy))
      else $error("stalled response changed");

   // Only a successful operation carries a handle
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_DONE) |-> (out_id == '0) && (out_priority == '0))
      else $error("failed operation returned data");

   // Full drop reports a full queue
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_FULL) |-> occupancy == OCC_W'(QUEUE_DEPTH))
      else $error("full status with wrong occupancy");

   // Empty status reports no entries
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_EMPTY) |-> occupancy == '0)
      else $error("empty status with entries left");

endmodule

bind ready_queue_priority_select rqps_checker u_rqps_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .out_id       (rsp_chan.out_id),
   .out_priority (rsp_chan.out_priority),
   .status       (rsp_chan.status),
   .occupancy    (rsp_chan.occupancy)
);
